// ===== rtl/code_pair_histogram_unit_macros.svh =====
// Assertion macros for the code pair histogram checker.
`ifndef CODE_PAIR_HISTOGRAM_UNIT_MACROS_SVH
`define CODE_PAIR_HISTOGRAM_UNIT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define CPH_ASSERT_SAME(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define CPH_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/cphist_pkg.sv =====
// Shared types and constants for the code pair histogram unit.
`timescale 1ns / 1ps
`default_nettype none

package cphist_pkg;

    // Fixed port field widths
    localparam int VID_W   = 12;
    localparam int SUB_W   = 3;
    localparam int CODE_W  = 8;
    localparam int COUNT_W = 13;

    // Saturation value of one bin counter
    localparam logic [COUNT_W-1:0] COUNT_MAX = 13'd8191;

    // Request codes carried by req_type
    typedef enum logic [1:0] {
        REQ_STORE = 2'd0,
        REQ_COUNT = 2'd1,
        REQ_READ  = 2'd2
    } req_t;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_LOOKUP,
        ST_UPDATE,
        ST_RESULT
    } state_t;

endpackage

`default_nettype wire

// ===== rtl/cphist_code_store.sv =====
// Code store memory: one write port, two registered read ports.
`timescale 1ns / 1ps
`default_nettype none

module cphist_code_store #(
    parameter int DEPTH = 32768,
    parameter int AW    = 15,
    parameter int DW    = 8
) (
    input  wire logic          aclk,
    input  wire logic          wr_en,
    input  wire logic [AW-1:0] wr_addr,
    input  wire logic [DW-1:0] wr_data,
    input  wire logic          rd_en,
    input  wire logic [AW-1:0] rd_addr_a,
    input  wire logic [AW-1:0] rd_addr_b,
    output logic      [DW-1:0] rd_data_a,
    output logic      [DW-1:0] rd_data_b
);

    logic [DW-1:0] code_mem [DEPTH];
    logic [DW-1:0] rd_data_a_reg;
    logic [DW-1:0] rd_data_b_reg;

    // Write port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            code_mem[wr_addr] <= wr_data;
        end
    end

    // Two read ports, data held until the next read
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_a_reg <= code_mem[rd_addr_a];
            rd_data_b_reg <= code_mem[rd_addr_b];
        end
    end

    assign rd_data_a = rd_data_a_reg;
    assign rd_data_b = rd_data_b_reg;

endmodule

`default_nettype wire

// ===== rtl/cphist_count_ram.sv =====
// Pair counter memory: one write port, one registered read port.
`timescale 1ns / 1ps
`default_nettype none

module cphist_count_ram
    import cphist_pkg::*;
#(
    parameter int DEPTH = 524288,
    parameter int AW    = 19
) (
    input  wire logic               aclk,
    input  wire logic               wr_en,
    input  wire logic [AW-1:0]      wr_addr,
    input  wire logic [COUNT_W-1:0] wr_data,
    input  wire logic               rd_en,
    input  wire logic [AW-1:0]      rd_addr,
    output logic      [COUNT_W-1:0] rd_data
);

    logic [COUNT_W-1:0] count_mem [DEPTH];
    logic [COUNT_W-1:0] rd_data_reg;

    // Write port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            count_mem[wr_addr] <= wr_data;
        end
    end

    // Read port, data held until the next read
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= count_mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

// ===== rtl/code_pair_histogram_unit.sv =====
// Top level of the code pair histogram unit: sequencer, memories and result register.
// Items are taken one at a time. A store item is written in the idle state; a count item
// passes through code lookup, counter read and write back; a read item reads the counter
// and waits for the result register to free. Pace is set by the read-modify-write through
// the counter memory. After reset a clearing pass zeroes NUM_SUBSPACES * 2^(2*CODE_BITS)
// counters, one per cycle (524288 by default), during which s_ready stays low.
`timescale 1ns / 1ps
`default_nettype none

module code_pair_histogram_unit
    import cphist_pkg::*;
#(
    parameter int NUM_SUBSPACES = 8,
    parameter int CODE_BITS     = 8,
    parameter int MAX_VECTORS   = 4096
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    // Input item channel
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire logic [1:0]         s_req_type,
    input  wire logic [VID_W-1:0]   s_vector_id,
    input  wire logic [VID_W-1:0]   s_neighbor_id,
    input  wire logic [SUB_W-1:0]   s_subspace,
    input  wire logic [CODE_W-1:0]  s_code_value,
    input  wire logic [CODE_W-1:0]  s_target_code,
    // Result item channel
    output logic                    m_valid,
    input  wire logic               m_ready,
    output logic      [COUNT_W-1:0] m_bin_count
);

    localparam int CODES       = 1 << CODE_BITS;
    localparam int BINS        = CODES * CODES;
    localparam int STORE_DEPTH = MAX_VECTORS * NUM_SUBSPACES;
    localparam int STORE_AW    = $clog2(STORE_DEPTH);
    localparam int CNT_DEPTH   = NUM_SUBSPACES * BINS;
    localparam int CNT_AW      = $clog2(CNT_DEPTH);
    localparam logic [CNT_AW-1:0] CLR_LAST = CNT_AW'(CNT_DEPTH - 1);

    // Flat store address of a (vector, subspace) code
    function automatic logic [STORE_AW-1:0] store_addr(
        input logic [VID_W-1:0] vid,
        input logic [SUB_W-1:0] sub
    );
        logic [31:0] wide;
        wide = 32'(vid) * 32'(NUM_SUBSPACES) + 32'(sub);
        return wide[STORE_AW-1:0];
    endfunction

    // Flat counter address of a (subspace, source code, neighbor code) bin
    function automatic logic [CNT_AW-1:0] bin_addr(
        input logic [SUB_W-1:0]     sub,
        input logic [CODE_BITS-1:0] src,
        input logic [CODE_BITS-1:0] tgt
    );
        logic [31:0] wide;
        wide = 32'(sub) * 32'(BINS) + 32'(src) * 32'(CODES) + 32'(tgt);
        return wide[CNT_AW-1:0];
    endfunction

    state_t               state_reg, state_next;
    logic [CNT_AW-1:0]    clr_addr_reg, clr_addr_next;
    logic [SUB_W-1:0]     sub_reg, sub_next;
    logic                 ok_reg, ok_next;
    logic [CNT_AW-1:0]    bin_addr_reg, bin_addr_next;
    logic                 m_valid_reg;
    logic [COUNT_W-1:0]   m_bin_count_reg;

    logic                 accept;
    logic                 sub_ok, vid_ok, nid_ok;
    logic [CNT_AW-1:0]    read_bin, count_bin;
    logic [CODE_BITS-1:0] src_code, tgt_code;
    logic                 out_free, out_load;
    logic [COUNT_W-1:0]   out_data;

    logic                 code_wr_en, code_rd_en;
    logic                 cnt_wr_en, cnt_rd_en;
    logic [CNT_AW-1:0]    cnt_wr_addr, cnt_rd_addr;
    logic [COUNT_W-1:0]   cnt_wr_data, cnt_rd_data;

    // Range checks on the incoming item
    assign sub_ok = 32'(s_subspace) < 32'(NUM_SUBSPACES);
    assign vid_ok = 32'(s_vector_id) < 32'(MAX_VECTORS);
    assign nid_ok = 32'(s_neighbor_id) < 32'(MAX_VECTORS);

    assign s_ready  = (state_reg == ST_IDLE);
    assign accept   = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;

    assign read_bin  = bin_addr(s_subspace, s_code_value[CODE_BITS-1:0],
                                s_target_code[CODE_BITS-1:0]);
    assign count_bin = bin_addr(sub_reg, src_code, tgt_code);

    cphist_code_store #(
        .DEPTH (STORE_DEPTH),
        .AW    (STORE_AW),
        .DW    (CODE_BITS)
    ) u_code_store (
        .aclk      (aclk),
        .wr_en     (code_wr_en),
        .wr_addr   (store_addr(s_vector_id, s_subspace)),
        .wr_data   (s_code_value[CODE_BITS-1:0]),
        .rd_en     (code_rd_en),
        .rd_addr_a (store_addr(s_vector_id, s_subspace)),
        .rd_addr_b (store_addr(s_neighbor_id, s_subspace)),
        .rd_data_a (src_code),
        .rd_data_b (tgt_code)
    );

    cphist_count_ram #(
        .DEPTH (CNT_DEPTH),
        .AW    (CNT_AW)
    ) u_count_ram (
        .aclk    (aclk),
        .wr_en   (cnt_wr_en),
        .wr_addr (cnt_wr_addr),
        .wr_data (cnt_wr_data),
        .rd_en   (cnt_rd_en),
        .rd_addr (cnt_rd_addr),
        .rd_data (cnt_rd_data)
    );

    // State register and item context
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_CLEAR;
            clr_addr_reg <= '0;
        end else begin
            state_reg    <= state_next;
            clr_addr_reg <= clr_addr_next;
        end
    end

    always_ff @(posedge aclk) begin
        sub_reg      <= sub_next;
        ok_reg       <= ok_next;
        bin_addr_reg <= bin_addr_next;
    end

    // Next state and memory controls
    always_comb begin
        state_next    = state_reg;
        clr_addr_next = clr_addr_reg;
        sub_next      = sub_reg;
        ok_next       = ok_reg;
        bin_addr_next = bin_addr_reg;
        code_wr_en    = 1'b0;
        code_rd_en    = 1'b0;
        cnt_rd_en     = 1'b0;
        cnt_rd_addr   = read_bin;
        cnt_wr_en     = 1'b0;
        cnt_wr_addr   = bin_addr_reg;
        cnt_wr_data   = '0;
        out_load      = 1'b0;
        out_data      = '0;

        unique case (state_reg)
            ST_CLEAR: begin
                cnt_wr_en   = 1'b1;
                cnt_wr_addr = clr_addr_reg;
                if (clr_addr_reg == CLR_LAST) begin
                    state_next = ST_IDLE;
                end else begin
                    clr_addr_next = clr_addr_reg + 1'b1;
                end
            end
            ST_IDLE: begin
                if (accept) begin
                    sub_next = s_subspace;
                    unique case (s_req_type)
                        REQ_STORE: begin
                            code_wr_en = sub_ok && vid_ok;
                        end
                        REQ_COUNT: begin
                            code_rd_en = 1'b1;
                            ok_next    = sub_ok && vid_ok && nid_ok;
                            state_next = ST_LOOKUP;
                        end
                        REQ_READ: begin
                            ok_next       = sub_ok;
                            bin_addr_next = read_bin;
                            cnt_rd_en     = sub_ok;
                            cnt_rd_addr   = read_bin;
                            state_next    = ST_RESULT;
                        end
                        default: begin
                            // unknown request: dropped
                        end
                    endcase
                end
            end
            ST_LOOKUP: begin
                // codes are back, fetch the bin
                if (ok_reg) begin
                    cnt_rd_en     = 1'b1;
                    cnt_rd_addr   = count_bin;
                    bin_addr_next = count_bin;
                    state_next    = ST_UPDATE;
                end else begin
                    state_next = ST_IDLE;
                end
            end
            ST_UPDATE: begin
                // saturating increment
                cnt_wr_en   = 1'b1;
                cnt_wr_data = (cnt_rd_data == COUNT_MAX) ? cnt_rd_data
                                                         : cnt_rd_data + 1'b1;
                state_next  = ST_IDLE;
            end
            ST_RESULT: begin
                // hand out the bin and clear it once the result register frees
                if (out_free) begin
                    out_load   = 1'b1;
                    out_data   = ok_reg ? cnt_rd_data : '0;
                    cnt_wr_en  = ok_reg;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_bin_count_reg <= out_data;
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_bin_count = m_bin_count_reg;

endmodule

`default_nettype wire

// ===== rtl/cphist_checker.sv =====
// Port-level checker for the code pair histogram unit, with its bind.
`timescale 1ns / 1ps
`default_nettype none

`include "code_pair_histogram_unit_macros.svh"

module cphist_checker
    import cphist_pkg::*;
(
    input wire logic               aclk,
    input wire logic               aresetn,
    input wire logic               s_valid,
    input wire logic               s_ready,
    input wire logic               m_valid,
    input wire logic               m_ready,
    input wire logic [COUNT_W-1:0] m_bin_count
);

    // Result handshake holds while stalled
    `CPH_ASSERT_NEXT(a_m_valid_hold, aclk, aresetn, m_valid && !m_ready, m_valid, "m_valid dropped while stalled")
    `CPH_ASSERT_NEXT(a_m_data_hold, aclk, aresetn, m_valid && !m_ready, $stable(m_bin_count), "m_bin_count changed while stalled")

    // An offered input item stays offered until it is taken
    `CPH_ASSERT_NEXT(a_s_valid_hold, aclk, aresetn, s_valid && !s_ready, s_valid, "s_valid dropped while waiting")

    // Clearing pass follows reset: s_ready is low right after reset is released
    `CPH_ASSERT_SAME(a_clear_after_reset, aclk, aresetn, !$past(aresetn), !s_ready, "item taken during clearing pass")

    // A new result only comes out of a cycle spent working on an item
    `CPH_ASSERT_SAME(a_result_from_work, aclk, aresetn, $rose(m_valid), !$past(s_ready), "result appeared while idle")

endmodule

bind code_pair_histogram_unit cphist_checker u_cphist_checker (
    .aclk        (aclk),
    .aresetn     (aresetn),
    .s_valid     (s_valid),
    .s_ready     (s_ready),
    .m_valid     (m_valid),
    .m_ready     (m_ready),
    .m_bin_count (m_bin_count)
);

`default_nettype wire
